@@ sv/scfr_pkg.sv @@
package scfr_pkg;

   localparam int MAX_PACKET = 16;
   localparam int NUM_PORTS  = 8;

   // Payload buffer index and frame length widths follow from the buffer size.
   localparam int IDX_W  = $clog2(MAX_PACKET);
   localparam int LEN_W  = $clog2(MAX_PACKET + 1);
   // A two-digit port number reaches 99.
   localparam int PNUM_W = 7;

   localparam logic [7:0] HDR_BYTE  = 8'hAA;
   localparam logic [7:0] CMD_PROBE = 8'h00;
   localparam logic [7:0] CMD_DATA  = 8'h01;

   localparam logic [2:0] KIND_PROBE    = 3'd0;
   localparam logic [2:0] KIND_MSG      = 3'd1;
   localparam logic [2:0] KIND_EMPTY    = 3'd2;
   localparam logic [2:0] KIND_BAD_CMD  = 3'd3;
   localparam logic [2:0] KIND_BAD_PORT = 3'd4;
   localparam logic [2:0] KIND_BAD_LEN  = 3'd5;

   localparam logic [0:0] REG_PORT_ENABLE  = 1'd0;
   localparam logic [0:0] REG_CONSOLE_MASK = 1'd1;

   typedef struct packed {
      logic       load_len;
      logic       store_byte;
      logic       latch_port;
      logic       init_drain;
      logic       take_held;
      logic       advance_idx;
      logic       emit;
      logic [2:0] emit_kind;
      logic       emit_last;
   } dp_cmd_type;

   typedef struct packed {
      logic rx_is_hdr;
      logic rx_is_probe;
      logic rx_is_data;
      logic len_bad;
      logic frame_done;
      logic port_bad;
      logic port_console;
      logic msg_short;
      logic rd_zero;
      logic have_held;
      logic idx_at_end;
      logic out_free;
   } dp_status_type;

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction

endpackage

@@ sv/serial_command_frame_receiver.sv @@
// Serial command frame receiver.
// Input channel (req_): one received serial byte per beat on req_rx_byte. The block
// drops bytes until header 0xAA, then takes a command byte: 0x00 gives a probe
// result, 0x01 opens a data frame (length byte, then that many payload bytes),
// anything else gives a bad command result. A frame's first two bytes name the port;
// for an enabled console port the rest of the payload, up to the first zero byte,
// comes out one message byte per beat, with rsp_last set on the final one.
// Result channel (rsp_): kind, port_id, data_byte and last per beat, from an output
// register, so a result appears in the cycle after the byte or step that causes it.
// Header, command, length and payload bytes are taken back to back while the result
// port is free. After the final payload byte the block stops taking input while it
// decodes the port (S_DEC, then S_PORT) and drains each message byte from the payload
// buffer by a registered read (S_WAIT) and an evaluation (S_EVAL).
// When the receiver holds rsp_stall, the pending result stays on the port and the
// block waits; while such a result is held, the input side is stalled as well.
// Configuration (csr_): csr_ready is always high; index 0 writes the port-enable
// mask and index 1 the console-port mask. Reset returns to header hunting and
// clears both masks; the payload buffer needs no clearing.
module serial_command_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [2:0] rsp_port_id,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_data
);
   import scfr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          in_ready;

   // The controller sequences the frame phases and the buffer drain.
   scfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .in_ready  (in_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the masks, frame counters, payload buffer and output register.
   scfr_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .rx_byte       (req_rx_byte),
      .cmd           (cmd),
      .status        (status),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_port_id   (rsp_port_id),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last      (rsp_last)
   );

   assign req_stall = !in_ready;
   // Register writes go straight into the mask registers, so the port never pushes back.
   assign csr_ready = 1'b1;

endmodule

@@ sv/scfr_ram.sv @@
module scfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/scfr_dp.sv @@
module scfr_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             rx_byte,
   input  scfr_pkg::dp_cmd_type   cmd,
   output scfr_pkg::dp_status_type status,
   input  logic                   csr_valid,
   input  logic [0:0]             csr_index,
   input  logic [7:0]             csr_data,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_kind,
   output logic [2:0]             rsp_port_id,
   output logic [7:0]             rsp_data_byte,
   output logic                   rsp_last
);
   import scfr_pkg::*;

   logic [7:0]        enable_ff, enable_in;
   logic [7:0]        console_ff, console_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  offset_ff, offset_in;
   logic [7:0]        b0_ff, b0_in;
   logic [7:0]        b1_ff, b1_in;
   logic [PNUM_W-1:0] port_ff, port_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [7:0]        held_ff, held_in;
   logic              have_held_ff, have_held_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        kind_ff, kind_in;
   logic [2:0]        port_id_ff, port_id_in;
   logic [7:0]        data_ff, data_in;
   logic              last_ff, last_in;

   logic [7:0]        rd_data;
   logic [PNUM_W-1:0] port_dec;
   logic [PNUM_W-1:0] d0_ext;
   logic [PNUM_W-1:0] d1_ext;
   logic              out_free;

   scfr_ram #(.WIDTH(8), .DEPTH(MAX_PACKET)) u_payload_ram (
      .clock   (clock),
      .wr_en   (cmd.store_byte),
      .wr_addr (offset_ff[IDX_W-1:0]),
      .wr_data (rx_byte),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   // Port number from the two leading payload bytes.
   always_comb begin
      d0_ext = {{(PNUM_W-4){1'b0}}, b0_ff[3:0]};
      d1_ext = {{(PNUM_W-4){1'b0}}, b1_ff[3:0]};
      if (!is_digit(b0_ff)) begin
         port_dec = '0;
      end else if ((len_ff >= LEN_W'(2)) && is_digit(b1_ff)) begin
         port_dec = (d0_ext << 3) + (d0_ext << 1) + d1_ext;
      end else begin
         port_dec = d0_ext;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      enable_in    = enable_ff;
      console_in   = console_ff;
      len_in       = len_ff;
      offset_in    = offset_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      port_in      = port_ff;
      rd_idx_in    = rd_idx_ff;
      held_in      = held_ff;
      have_held_in = have_held_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      port_id_in   = port_id_ff;
      data_in      = data_ff;
      last_in      = last_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_PORT_ENABLE:  enable_in  = csr_data;
            REG_CONSOLE_MASK: console_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.load_len) begin
         len_in    = rx_byte[LEN_W-1:0];
         offset_in = '0;
      end
      if (cmd.store_byte) begin
         offset_in = offset_ff + LEN_W'(1);
         if (offset_ff == LEN_W'(0)) begin
            b0_in = rx_byte;
         end
         if (offset_ff == LEN_W'(1)) begin
            b1_in = rx_byte;
         end
      end
      if (cmd.latch_port) begin
         port_in = port_dec;
      end
      if (cmd.init_drain) begin
         rd_idx_in    = IDX_W'(2);
         have_held_in = 1'b0;
      end
      if (cmd.take_held) begin
         held_in      = rd_data;
         have_held_in = 1'b1;
      end
      if (cmd.advance_idx) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = cmd.emit_kind;
         last_in      = cmd.emit_last;
         port_id_in   = '0;
         data_in      = '0;
         if (cmd.emit_kind inside {KIND_MSG, KIND_EMPTY}) begin
            port_id_in = port_ff[2:0];
         end
         if (cmd.emit_kind == KIND_MSG) begin
            data_in = held_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         console_ff   <= '0;
         len_ff       <= '0;
         offset_ff    <= '0;
         have_held_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         console_ff   <= console_in;
         len_ff       <= len_in;
         offset_ff    <= offset_in;
         have_held_ff <= have_held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b0_ff      <= b0_in;
      b1_ff      <= b1_in;
      port_ff    <= port_in;
      rd_idx_ff  <= rd_idx_in;
      held_ff    <= held_in;
      kind_ff    <= kind_in;
      port_id_ff <= port_id_in;
      data_ff    <= data_in;
      last_ff    <= last_in;
   end

   always_comb begin
      status.rx_is_hdr    = (rx_byte == HDR_BYTE);
      status.rx_is_probe  = (rx_byte == CMD_PROBE);
      status.rx_is_data   = (rx_byte == CMD_DATA);
      status.len_bad      = (rx_byte == 8'd0) || (rx_byte > 8'(MAX_PACKET));
      status.frame_done   = ({1'b0, offset_ff} + (LEN_W+1)'(1)) >= {1'b0, len_ff};
      status.port_bad     = (port_ff >= PNUM_W'(NUM_PORTS)) || !enable_ff[port_ff[2:0]];
      status.port_console = console_ff[port_ff[2:0]];
      status.msg_short    = (len_ff <= LEN_W'(2));
      status.rd_zero      = (rd_data == 8'd0);
      status.have_held    = have_held_ff;
      status.idx_at_end   = ({{(LEN_W-IDX_W){1'b0}}, rd_idx_ff} + LEN_W'(1)) >= len_ff;
      status.out_free     = out_free;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_port_id   = port_id_ff;
   assign rsp_data_byte = data_ff;
   assign rsp_last      = last_ff;

endmodule

@@ sv/scfr_ctrl.sv @@
module scfr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    in_ready,
   input  scfr_pkg::dp_status_type status,
   output scfr_pkg::dp_cmd_type    cmd
);
   import scfr_pkg::*;

   localparam logic [2:0] S_HDR  = 3'd0;
   localparam logic [2:0] S_CMD  = 3'd1;
   localparam logic [2:0] S_LEN  = 3'd2;
   localparam logic [2:0] S_PAY  = 3'd3;
   localparam logic [2:0] S_DEC  = 3'd4;
   localparam logic [2:0] S_PORT = 3'd5;
   localparam logic [2:0] S_WAIT = 3'd6;
   localparam logic [2:0] S_EVAL = 3'd7;
   // A held byte waiting to go out as the final message byte reuses the
   // decode slot, which otherwise latches the port and always moves on to S_PORT.
   localparam logic [2:0] S_LAST = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       last_pending_ff, last_pending_in;
   logic       accept;

   assign in_ready = (state_ff inside {S_HDR, S_CMD, S_LEN, S_PAY}) && status.out_free;
   assign accept   = req_valid && in_ready;

   always_comb begin
      state_in        = state_ff;
      last_pending_in = last_pending_ff;
      cmd             = '0;

      case (state_ff)
         S_HDR: begin
            if (accept && status.rx_is_hdr) begin
               state_in = S_CMD;
            end
         end
         S_CMD: begin
            if (accept) begin
               if (status.rx_is_probe) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_PROBE;
                  cmd.emit_last = 1'b1;
                  state_in      = S_HDR;
               end else if (status.rx_is_data) begin
                  state_in = S_LEN;
               end else begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_BAD_CMD;
                  cmd.emit_last = 1'b1;
                  state_in      = S_HDR;
               end
            end
         end
         S_LEN: begin
            if (accept) begin
               if (status.len_bad) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_BAD_LEN;
                  cmd.emit_last = 1'b1;
                  state_in      = S_HDR;
               end else begin
                  cmd.load_len = 1'b1;
                  state_in     = S_PAY;
               end
            end
         end
         S_PAY: begin
            if (accept) begin
               cmd.store_byte = 1'b1;
               if (status.frame_done) begin
                  last_pending_in = 1'b0;
                  state_in        = S_DEC;
               end
            end
         end
         S_DEC: begin
            if (last_pending_ff) begin
               if (status.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_kind   = KIND_MSG;
                  cmd.emit_last   = 1'b1;
                  last_pending_in = 1'b0;
                  state_in        = S_HDR;
               end
            end else begin
               cmd.latch_port = 1'b1;
               state_in       = S_PORT;
            end
         end
         S_PORT: begin
            if (status.port_bad) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_BAD_PORT;
                  cmd.emit_last = 1'b1;
                  state_in      = S_HDR;
               end
            end else if (!status.port_console) begin
               state_in = S_HDR;
            end else if (status.msg_short) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_EMPTY;
                  cmd.emit_last = 1'b1;
                  state_in      = S_HDR;
               end
            end else begin
               cmd.init_drain = 1'b1;
               state_in       = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (status.rd_zero) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = status.have_held ? KIND_MSG : KIND_EMPTY;
                  cmd.emit_last = 1'b1;
                  state_in      = S_HDR;
               end
            end else if (!status.have_held || status.out_free) begin
               // The held byte goes out only once its successor is known.
               cmd.emit      = status.have_held;
               cmd.emit_kind = KIND_MSG;
               cmd.emit_last = 1'b0;
               cmd.take_held = 1'b1;
               if (status.idx_at_end) begin
                  last_pending_in = 1'b1;
                  state_in        = S_LAST;
               end else begin
                  cmd.advance_idx = 1'b1;
                  state_in        = S_WAIT;
               end
            end
         end
         default: begin
            state_in = S_HDR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_HDR;
         last_pending_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         last_pending_ff <= last_pending_in;
      end
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result issued while the output register was occupied");

   a_advance_then_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.advance_idx |=> state_ff == S_WAIT)
      else $error("buffer read not given a cycle to settle");

   a_frame_end_decodes: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff == S_PAY && status.frame_done) |=>
      (state_ff == S_DEC && !last_pending_ff))
      else $error("frame end did not start port decode");

   a_no_drain_on_input: assert property (@(posedge clock) disable iff (reset)
      cmd.store_byte |-> !(cmd.take_held || cmd.advance_idx || cmd.init_drain))
      else $error("buffer write overlapped with a drain step");

endmodule
